// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the clock, off during reset.
`define KWS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define KWS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/kws_pkg.sv
`timescale 1ns / 1ps
package kws_pkg;

	localparam int XPOS_W    = 23;
	localparam int WEIGHT_W  = 32;
	localparam int ALPHA_W   = 30;
	localparam int SCALE_W   = 32;
	localparam int HLEN_W    = 27;
	localparam int DIV_NUM_W = 80;
	localparam int DIV_DEN_W = 28;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [1:0] {
		REG_ALPHA = 2'd0,
		REG_SCALE = 2'd1,
		REG_HLEN  = 2'd2
	} cfg_reg_t;

	// Fraction bits of the series sum for each integer part of alpha.
	function automatic logic [63:0][5:0] build_frac_tab();
		logic [63:0][5:0] tab;
		int b;
		for (int e = 0; e < 64; e++) begin
			b = ((e + 1) * 1443 + 999) / 1000 + 1;
			tab[e] = (b > 63) ? 6'd0 : 6'(63 - b);
		end
		return tab;
	endfunction

	localparam logic [63:0][5:0] FRAC_TAB = build_frac_tab();

endpackage

// File: rtl/core/kws_mul.sv
`timescale 1ns / 1ps
module kws_mul import kws_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] prod,
	output unit_stat_t   stat
);

	logic [63:0]  a_q, b_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q;
	logic [63:0]  pp_s1;
	logic [1:0]   sh_s1;
	logic         pp_vld_s1;
	logic [127:0] acc_q;
	logic [31:0]  a_part, b_part;
	logic [127:0] pp_ext;

	assign a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		unique case (sh_s1)
			2'd0:    pp_ext = {64'd0, pp_s1};
			2'd1:    pp_ext = {32'd0, pp_s1, 32'd0};
			2'd2:    pp_ext = {pp_s1, 64'd0};
			default: pp_ext = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q       <= '0;
			b_q       <= '0;
			cnt_q     <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			pp_s1     <= '0;
			sh_s1     <= '0;
			pp_vld_s1 <= 1'b0;
			acc_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q       <= a;
				b_q       <= b;
				cnt_q     <= '0;
				busy_q    <= 1'b1;
				acc_q     <= '0;
				pp_vld_s1 <= 1'b0;
			end else if (busy_q) begin
				// one 32x32 partial product a cycle, accumulate the one before
				if (!cnt_q[2]) begin
					pp_s1     <= a_part * b_part;
					sh_s1     <= 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});
					pp_vld_s1 <= 1'b1;
					cnt_q     <= cnt_q + 3'd1;
				end else begin
					pp_vld_s1 <= 1'b0;
					busy_q    <= 1'b0;
					done_q    <= 1'b1;
				end
				if (pp_vld_s1) begin
					acc_q <= acc_q + pp_ext;
				end
			end
		end
	end

	assign prod      = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: rtl/core/kws_div.sv
`timescale 1ns / 1ps
module kws_div import kws_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic [DIV_NUM_W-1:0] quot,
	output unit_stat_t           stat
);

	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] rem_q, den_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q, done_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic                 fits;

	assign rem_sh = {rem_q, num_q[DIV_NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// restoring step: one quotient bit a cycle
				rem_q <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
				num_q <= {num_q[DIV_NUM_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot      = num_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: rtl/core/kws_sqrt.sv
`timescale 1ns / 1ps
module kws_sqrt import kws_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [62:0] val,
	output logic [31:0] root,
	output unit_stat_t  stat
);

	logic [63:0] v_q, res_q, pos_q;
	logic        busy_q, done_q;
	logic [63:0] trial;

	assign trial = res_q + pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			res_q  <= '0;
			pos_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				v_q    <= {1'b0, val};
				res_q  <= '0;
				pos_q  <= 64'h4000_0000_0000_0000;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// one result bit a cycle
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + pos_q;
				end else begin
					res_q <= res_q >> 1;
				end
				pos_q <= pos_q >> 2;
				if (pos_q == 64'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign root      = res_q[31:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: rtl/core/kaiser_window_sample_core.sv
`timescale 1ns / 1ps
// Kaiser window sampler: weight = scale * I0(alpha * sqrt(1 - x^2/L)), zero outside.
// The series runs only for positions inside the window; positions outside skip to the output.
// One item at a time: s_axis_tready rises in the same cycle that the weight is presented.
// Each series term uses the multiplier and then the bit-serial divider.
// arst_n clears the sequencer and output valid and loads the register defaults.
`include "assert_macros.svh"
module kaiser_window_sample_core import kws_pkg::*; #(
	parameter int SERIES_TERMS = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	// input positions
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [22:0] x_pos
	// window weights
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] weight
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int K_W = $clog2(SERIES_TERMS);

	typedef enum logic [3:0] {
		S_IDLE, S_SQR, S_CHK, S_DIVR, S_SQRT, S_Y, S_Q, S_TMUL, S_TDIV, S_FMUL, S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [ALPHA_W-1:0] alpha_q;
	logic [SCALE_W-1:0] scale_q;
	logic [HLEN_W-1:0]  hlen_q;

	// datapath registers
	logic [44:0]         xx_q;
	logic [63:0]         q_q, sum_q;
	logic [K_W-1:0]      k_q;
	logic [WEIGHT_W-1:0] res_q;
	logic                out_valid_q;
	logic [WEIGHT_W-1:0] out_data_q;

	// shared unit operands and start requests
	logic [63:0]          mul_a_q, mul_b_q;
	logic                 mul_start_q;
	logic [DIV_NUM_W-1:0] div_num_q;
	logic [DIV_DEN_W-1:0] div_den_q;
	logic                 div_start_q;
	logic [62:0]          sqrt_v_q;
	logic                 sqrt_start_q;

	logic [127:0]         mul_prod;
	logic [DIV_NUM_W-1:0] div_quot;
	logic [31:0]          sqrt_root;
	unit_stat_t           mul_stat, div_stat, sqrt_stat;

	// combinational helpers
	logic [XPOS_W-1:0]    raw, mag;
	logic [5:0]           frac;
	logic [32:0]          r_clamp, u_val;
	logic [63:0]          t_new;
	logic [64:0]          sum_wide;
	logic [63:0]          sum_new;
	logic [2*K_W-1:0]     kk;
	logic [127:0]         fin_shift;
	logic [WEIGHT_W-1:0]  fin_weight;

	assign raw  = s_axis_tdata[XPOS_W-1:0];
	assign mag  = raw[XPOS_W-1] ? (~raw + 1'b1) : raw;
	assign frac = FRAC_TAB[alpha_q[ALPHA_W-1:24]];

	// ratio x^2/L clamped to 1.0, then 1 - ratio
	assign r_clamp = (div_quot > DIV_NUM_W'(64'h1_0000_0000)) ? 33'h1_0000_0000 : div_quot[32:0];
	assign u_val   = 33'h1_0000_0000 - r_clamp;

	// next series term and running sum, both saturating
	assign t_new    = (|div_quot[DIV_NUM_W-1:64]) ? '1 : div_quot[63:0];
	assign sum_wide = {1'b0, sum_q} + {1'b0, t_new};
	assign sum_new  = sum_wide[64] ? '1 : sum_wide[63:0];
	assign kk       = {{K_W{1'b0}}, k_q} * {{K_W{1'b0}}, k_q};

	// final scale, drop the sum's fraction bits, clamp at 1.0
	assign fin_shift  = mul_prod >> frac;
	assign fin_weight = ((|fin_shift[127:32]) || (fin_shift[31:0] > 32'h8000_0000))
		? 32'h8000_0000 : fin_shift[31:0];

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign cfg_ready     = 1'b1;

	// register writes; mask to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			scale_q <= 32'h8000_0000;
			hlen_q  <= 27'd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ALPHA: alpha_q <= cfg_data[ALPHA_W-1:0];
				REG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				REG_HLEN:  hlen_q  <= cfg_data[HLEN_W-1:0];
				default:   ;
			endcase
		end
	end

	// sequencer: the shared units run one at a time; S_CHK and S_DONE wait on no unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			xx_q         <= '0;
			q_q          <= '0;
			sum_q        <= '0;
			k_q          <= '0;
			res_q        <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			mul_a_q      <= '0;
			mul_b_q      <= '0;
			mul_start_q  <= 1'b0;
			div_num_q    <= '0;
			div_den_q    <= '0;
			div_start_q  <= 1'b0;
			sqrt_v_q     <= '0;
			sqrt_start_q <= 1'b0;
		end else begin
			mul_start_q  <= 1'b0;
			div_start_q  <= 1'b0;
			sqrt_start_q <= 1'b0;

			// drop the held weight once taken; S_DONE handles its own refill
			if (m_axis_tready && out_valid_q && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						mul_a_q     <= 64'(mag);
						mul_b_q     <= 64'(mag);
						mul_start_q <= 1'b1;
						state_q     <= S_SQR;
					end
				end
				S_SQR: begin
					if (mul_stat.done) begin
						xx_q    <= mul_prod[44:0];
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					priority if (xx_q > {2'b00, hlen_q, 16'd0}) begin
						res_q   <= '0;
						state_q <= S_DONE;
					end else if (hlen_q == '0) begin
						// only the center is inside: ratio is zero
						sqrt_v_q     <= {33'h1_0000_0000, 30'd0};
						sqrt_start_q <= 1'b1;
						state_q      <= S_SQRT;
					end else begin
						div_num_q   <= DIV_NUM_W'({xx_q, 16'd0});
						div_den_q   <= DIV_DEN_W'(hlen_q);
						div_start_q <= 1'b1;
						state_q     <= S_DIVR;
					end
				end
				S_DIVR: begin
					if (div_stat.done) begin
						sqrt_v_q     <= {u_val, 30'd0};
						sqrt_start_q <= 1'b1;
						state_q      <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_stat.done) begin
						mul_a_q     <= 64'(alpha_q);
						mul_b_q     <= 64'(sqrt_root);
						mul_start_q <= 1'b1;
						state_q     <= S_Y;
					end
				end
				S_Y: begin
					// half the argument in Q.32, squared next
					if (mul_stat.done) begin
						mul_a_q     <= 64'(mul_prod[61:24]);
						mul_b_q     <= 64'(mul_prod[61:24]);
						mul_start_q <= 1'b1;
						state_q     <= S_Q;
					end
				end
				S_Q: begin
					if (mul_stat.done) begin
						q_q         <= mul_prod[95:32];
						sum_q       <= 64'd1 << frac;
						k_q         <= K_W'(1);
						mul_a_q     <= 64'd1 << frac;
						mul_b_q     <= mul_prod[95:32];
						mul_start_q <= 1'b1;
						state_q     <= S_TMUL;
					end
				end
				S_TMUL: begin
					if (mul_stat.done) begin
						div_num_q   <= mul_prod[DIV_NUM_W+31:32];
						div_den_q   <= DIV_DEN_W'(kk);
						div_start_q <= 1'b1;
						state_q     <= S_TDIV;
					end
				end
				S_TDIV: begin
					if (div_stat.done) begin
						sum_q       <= sum_new;
						mul_start_q <= 1'b1;
						if (k_q == K_W'(SERIES_TERMS - 1)) begin
							mul_a_q <= 64'(scale_q);
							mul_b_q <= sum_new;
							state_q <= S_FMUL;
						end else begin
							k_q     <= k_q + 1'b1;
							mul_a_q <= t_new;
							mul_b_q <= q_q;
							state_q <= S_TMUL;
						end
					end
				end
				S_FMUL: begin
					if (mul_stat.done) begin
						res_q   <= fin_weight;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	kws_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.prod   (mul_prod),
		.stat   (mul_stat)
	);

	kws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	kws_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start_q),
		.val    (sqrt_v_q),
		.root   (sqrt_root),
		.stat   (sqrt_stat)
	);

	`KWS_ASSERT_IMPL(a_mul_no_overlap, mul_start_q, !mul_stat.busy, "multiplier restarted while busy")
	`KWS_ASSERT_IMPL(a_div_no_overlap, div_start_q, !div_stat.busy, "divider restarted while busy")
	`KWS_ASSERT_IMPL(a_weight_max, m_axis_tvalid, m_axis_tdata <= 32'h8000_0000, "weight above 1.0")
	`KWS_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "took two items")
	`KWS_ASSERT_IMPL(a_term_range, state_q == S_TDIV, k_q != '0, "series index zero in term step")

endmodule
